[sv/integer_to_ascii_radix_unit_assert.svh]
// assertion macros for the integer to ascii radix unit
`ifndef INTEGER_TO_ASCII_RADIX_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define ITAR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ITAR_ASSERT_IN_RESET(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ITAR_ASSERT(name, prop, msg)

`define ITAR_ASSERT_IN_RESET(name, prop, msg)

`endif

`endif

[sv/itar_pkg.sv]
// shared types, constants and the digit encoder of the integer to ascii radix unit
`default_nettype none

package itar_pkg;

  localparam int unsigned RadixWidth = 6;
  localparam int unsigned AddrWidth  = 3;

  localparam logic                  RadixIdx     = 1'b0;
  localparam logic [RadixWidth-1:0] RadixReset   = 6'd10;
  localparam logic [RadixWidth-1:0] RadixMin     = 6'd2;
  localparam logic [RadixWidth-1:0] RadixMax     = 6'd36;
  localparam logic [RadixWidth-1:0] DecimalRadix = 6'd10;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharA     = 8'h61;
  localparam logic [7:0] CharMinus = 8'h2d;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } itar_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push_digit;
    logic push_sign;
    logic rd;
    logic pop;
  } itar_cmd_t;

  typedef struct packed {
    logic div_last;
    logic quot_zero;
    logic full_next;
    logic neg;
    logic ptr_one;
  } itar_status_t;

  function automatic logic [7:0] digit_char(input logic [RadixWidth-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d > 6'd9) begin
      digit_char = d8 - 8'd10 + CharA;
    end else begin
      digit_char = d8 + CharZero;
    end
  endfunction

endpackage

`default_nettype wire

[sv/integer_to_ascii_radix_unit.sv]
// top level of the integer to ascii radix unit: config register, controller and datapath
`default_nettype none

// Converts one signed integer word into its text in the programmed radix (2 to 36,
// values below clamp to 2, above to 36), most significant character first, digits
// above nine as lower-case letters, with tlast on the final character. In radix ten
// a negative value is preceded by '-'; other radixes read the value as unsigned.
// Text longer than MAX_CHARS keeps only its least significant characters. Each digit
// comes from a one-bit-per-cycle restoring divider and is pushed onto the character
// stack, a sign last; the characters are then read from the stack and presented one
// by one, held while the receiver stalls. A new word is taken only once the last
// character of the previous one has been delivered. Write radix at byte
// address 0 only while the unit is idle.

`include "integer_to_ascii_radix_unit_assert.svh"

module integer_to_ascii_radix_unit #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_CHARS   = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // value (VALUE_WIDTH bits, signed), zero padded to whole bytes
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // character (8 bits)
  output logic [7:0]                          m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [itar_pkg::AddrWidth-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [itar_pkg::RadixWidth-1:0] radix_q, radix_d;
  logic [itar_pkg::RadixWidth-1:0] radix_eff;
  logic                            radix_sel;
  itar_pkg::itar_cmd_t             cmd;
  itar_pkg::itar_status_t          status;
  logic                            in_word_acc;
  logic                            out_last_acc;

  assign pready    = 1'b1;
  assign radix_sel = paddr[itar_pkg::AddrWidth-1] == itar_pkg::RadixIdx;

  always_comb begin
    radix_d = radix_q;
    if (psel && penable && pwrite && pready && radix_sel) begin
      radix_d = pwdata[itar_pkg::RadixWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itar_pkg::RadixReset;
    end else begin
      radix_q <= radix_d;
    end
  end

  assign prdata = radix_sel ? {{(32 - itar_pkg::RadixWidth){1'b0}}, radix_q} : 32'd0;

  always_comb begin
    if (radix_q < itar_pkg::RadixMin) begin
      radix_eff = itar_pkg::RadixMin;
    end else if (radix_q > itar_pkg::RadixMax) begin
      radix_eff = itar_pkg::RadixMax;
    end else begin
      radix_eff = radix_q;
    end
  end

  itar_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  itar_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_CHARS   (MAX_CHARS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (s_axis_tdata[VALUE_WIDTH-1:0]),
    .radix_i  (radix_eff),
    .status_o (status),
    .char_o   (m_axis_tdata)
  );

  assign m_axis_tlast = status.ptr_one;

  assign in_word_acc  = s_axis_tvalid && s_axis_tready;
  assign out_last_acc = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  `ITAR_ASSERT(a_busy_or_idle, s_axis_tready |-> !m_axis_tvalid, "input and output both open")
  `ITAR_ASSERT(a_accept_busy, in_word_acc |=> !s_axis_tready, "second word taken while busy")
  `ITAR_ASSERT(a_last_frees, out_last_acc |=> s_axis_tready, "not idle after last character")
  `ITAR_ASSERT_IN_RESET(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "output word during reset")

endmodule

`default_nettype wire

[sv/itar_datapath.sv]
// datapath: bit-serial radix divider, character stack and output word register
`default_nettype none

module itar_datapath #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_CHARS   = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire itar_pkg::itar_cmd_t                 cmd_i,
  input  wire logic [VALUE_WIDTH-1:0]              value_i,
  input  wire logic [itar_pkg::RadixWidth-1:0]     radix_i,
  output itar_pkg::itar_status_t                   status_o,
  output logic [7:0]                               char_o
);

  localparam int unsigned BitW = $clog2(VALUE_WIDTH);
  localparam int unsigned PtrW = $clog2(MAX_CHARS + 1);
  localparam int unsigned AdrW = $clog2(MAX_CHARS);

  logic [VALUE_WIDTH-1:0]          quot_q, quot_d;
  logic [itar_pkg::RadixWidth-1:0] rem_q, rem_d;
  logic [BitW-1:0]                 bit_q, bit_d;
  logic [PtrW-1:0]                 wptr_q, wptr_d;
  logic                            neg_q, neg_d;
  logic [7:0]                      rdata_q;
  logic [7:0]                      mem [MAX_CHARS];

  logic [itar_pkg::RadixWidth:0]   trial;
  logic [itar_pkg::RadixWidth:0]   trial_sub;
  logic                            trial_ge;
  logic [PtrW-1:0]                 wptr_dec;
  logic                            wr_en;
  logic [7:0]                      wr_data;

  // one restoring step: shift in the next dividend bit and try the radix
  assign trial     = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign trial_ge  = trial >= {1'b0, radix_i};
  assign trial_sub = trial - {1'b0, radix_i};
  assign wptr_dec  = wptr_q - PtrW'(1);

  assign wr_en   = cmd_i.push_digit | cmd_i.push_sign;
  assign wr_data = cmd_i.push_sign ? itar_pkg::CharMinus : itar_pkg::digit_char(rem_q);

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    bit_d  = bit_q;
    wptr_d = wptr_q;
    neg_d  = neg_q;
    if (cmd_i.load) begin
      rem_d  = '0;
      bit_d  = '0;
      wptr_d = '0;
      if (radix_i == itar_pkg::DecimalRadix && value_i[VALUE_WIDTH-1]) begin
        neg_d  = 1'b1;
        quot_d = ~value_i + VALUE_WIDTH'(1);
      end else begin
        neg_d  = 1'b0;
        quot_d = value_i;
      end
    end else if (cmd_i.div_step) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], trial_ge};
      rem_d  = trial_ge ? trial_sub[itar_pkg::RadixWidth-1:0]
                        : trial[itar_pkg::RadixWidth-1:0];
      bit_d  = bit_q + BitW'(1);
    end else if (cmd_i.push_digit) begin
      rem_d  = '0;
      bit_d  = '0;
      wptr_d = wptr_q + PtrW'(1);
    end else if (cmd_i.push_sign) begin
      wptr_d = wptr_q + PtrW'(1);
    end else if (cmd_i.pop) begin
      wptr_d = wptr_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      wptr_q <= '0;
      neg_q  <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      wptr_q <= wptr_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  // stack of characters, least significant first; read back from the top
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wptr_q[AdrW-1:0]] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[wptr_dec[AdrW-1:0]];
    end
  end

  assign status_o.div_last  = bit_q == BitW'(VALUE_WIDTH - 1);
  assign status_o.quot_zero = quot_q == '0;
  assign status_o.full_next = wptr_q == PtrW'(MAX_CHARS - 1);
  assign status_o.neg       = neg_q;
  assign status_o.ptr_one   = wptr_q == PtrW'(1);
  assign char_o             = rdata_q;

endmodule

`default_nettype wire

[sv/itar_ctrl.sv]
// controller: sequences load, digit division, stack pushes and character output
`default_nettype none

module itar_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire itar_pkg::itar_status_t status_i,
  output itar_pkg::itar_cmd_t         cmd_o
);

  itar_pkg::itar_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itar_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      itar_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = itar_pkg::ST_DIV;
        end
      end
      itar_pkg::ST_DIV: begin
        if (status_i.div_last) begin
          state_d = itar_pkg::ST_PUSH;
        end
      end
      itar_pkg::ST_PUSH: begin
        // stop on a zero quotient or when the stack is about to fill
        if (status_i.quot_zero || status_i.full_next) begin
          if (status_i.neg && !status_i.full_next) begin
            state_d = itar_pkg::ST_SIGN;
          end else begin
            state_d = itar_pkg::ST_READ;
          end
        end else begin
          state_d = itar_pkg::ST_DIV;
        end
      end
      itar_pkg::ST_SIGN: begin
        state_d = itar_pkg::ST_READ;
      end
      itar_pkg::ST_READ: begin
        state_d = itar_pkg::ST_SHOW;
      end
      itar_pkg::ST_SHOW: begin
        if (out_ready_i) begin
          state_d = status_i.ptr_one ? itar_pkg::ST_IDLE : itar_pkg::ST_READ;
        end
      end
      default: begin
        state_d = itar_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      itar_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      itar_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      itar_pkg::ST_PUSH: begin
        cmd_o.push_digit = 1'b1;
      end
      itar_pkg::ST_SIGN: begin
        cmd_o.push_sign = 1'b1;
      end
      itar_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      itar_pkg::ST_SHOW: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[test/tb_integer_to_ascii_radix_unit.sv]
// self-checking testbench of the integer to ascii radix unit
`timescale 1ns / 1ps

module tb_integer_to_ascii_radix_unit;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MaxChars   = 32;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned DrainCycles = 500;
  localparam int unsigned DirRows    = 23;
  localparam int unsigned PhaseItems = 22;
  localparam logic [itar_pkg::AddrWidth-1:0] RadixAddr = {itar_pkg::RadixIdx, 2'b00};

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b1;
  logic [31:0] s_axis_tdata  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [itar_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  char_word_t  text_due_q[$];
  logic [5:0]  radix_now = itar_pkg::RadixReset;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  bit          calm = 1'b0;

  integer_to_ascii_radix_unit #(
    .VALUE_WIDTH(ValueWidth),
    .MAX_CHARS  (MaxChars)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),  // value
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),  // character
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // text of one number in the given radix register setting, queued word by word
  function automatic void queue_text_of(input logic [31:0] value, input logic [5:0] reg_radix);
    logic [31:0] base;
    logic [31:0] mag;
    logic [31:0] digit;
    logic        neg;
    logic [7:0]  text[$];
    char_word_t  w;
    base = (reg_radix < itar_pkg::RadixMin) ? 32'(itar_pkg::RadixMin) :
           (reg_radix > itar_pkg::RadixMax) ? 32'(itar_pkg::RadixMax) : 32'(reg_radix);
    neg  = (base == 32'(itar_pkg::DecimalRadix)) && value[31];
    mag  = neg ? (~value + 32'd1) : value;
    if (mag == 0) text.push_front(itar_pkg::CharZero);
    while (mag != 0) begin
      digit = mag % base;
      text.push_front((digit > 9) ? 8'(digit - 10) + itar_pkg::CharA
                                  : 8'(digit) + itar_pkg::CharZero);
      mag = mag / base;
    end
    if (neg) text.push_front(itar_pkg::CharMinus);
    // only the least significant characters survive an overlong text
    while (text.size() > MaxChars) void'(text.pop_front());
    foreach (text[k]) begin
      w.code = text[k];
      w.last = (k == text.size() - 1);
      text_due_q.push_back(w);
    end
  endfunction

  function automatic void queue_typed_text(input string s);
    char_word_t w;
    for (int k = 0; k < s.len(); k++) begin
      w.code = s[k];
      w.last = (k == s.len() - 1);
      text_due_q.push_back(w);
    end
  endfunction

  // directed rows: radix setting, value, and the text where it is obvious
  task automatic fetch_row(input int idx, output logic [5:0] r, output logic [31:0] v,
                           output string t);
    t = "";
    case (idx)
      0:  begin r = 6'd10; v = 32'd0;          t = "0";           end
      1:  begin r = 6'd10; v = 32'h7fffffff;   t = "2147483647";  end
      2:  begin r = 6'd10; v = 32'h80000000;   t = "-2147483648"; end
      3:  begin r = 6'd10; v = 32'hffffffff;   t = "-1";          end
      4:  begin r = 6'd10; v = 32'd9;          t = "9";           end
      5:  begin r = 6'd10; v = -32'sd100;                         end
      6:  begin r = 6'd10; v = 32'd1234567890;                    end
      7:  begin r = 6'd16; v = 32'hffffffff;   t = "ffffffff";    end
      8:  begin r = 6'd16; v = 32'h80000000;   t = "80000000";    end
      9:  begin r = 6'd16; v = 32'h0123abcd;                      end
      10: begin
        r = 6'd2;
        v = 32'hffffffff;
        t = {"11111111", "11111111", "11111111", "11111111"};
      end
      11: begin r = 6'd2;  v = 32'd0;          t = "0";           end
      12: begin
        r = 6'd2;
        v = 32'h80000000;
        t = {"10000000", "00000000", "00000000", "00000000"};
      end
      13: begin r = 6'd36; v = 32'd35;         t = "z";           end
      14: begin r = 6'd36; v = 32'd36;         t = "10";          end
      15: begin r = 6'd36; v = 32'hffffffff;   t = "1z141z3";     end
      16: begin r = 6'd0;  v = 32'd5;          t = "101";         end
      17: begin r = 6'd1;  v = 32'd2;          t = "10";          end
      18: begin r = 6'd37; v = 32'd35;         t = "z";           end
      19: begin r = 6'd63; v = 32'd36;         t = "10";          end
      20: begin r = 6'd8;  v = 32'hffffffff;   t = "37777777777"; end
      21: begin r = 6'd8;  v = 32'h80000000;   t = "20000000000"; end
      default: begin r = 6'd3; v = 32'hffffffff; end
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      6:       pick_value = $urandom_range(40);
      7:       pick_value = -32'($urandom_range(40, 1));
      8:       pick_value = $urandom >> $urandom_range(31);
      9: begin
        case ($urandom_range(3))
          0:       pick_value = 32'd0;
          1:       pick_value = 32'h80000000;
          2:       pick_value = 32'h7fffffff;
          default: pick_value = 32'hffffffff;
        endcase
      end
      default: pick_value = $urandom;
    endcase
  endfunction

  // apb write of the radix register, then a read back of what it holds
  task automatic write_radix(input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RadixAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    radix_now = data[5:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {26'd0, data[5:0]}) begin
      $error("radix readback: expected %h, actual %h", {26'd0, data[5:0]}, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // a new radix is to be written only once every character is out; the unit does not enforce it
  task automatic change_radix(input logic [31:0] data);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (text_due_q.size() != 0) @(posedge clk_i);
    write_radix(data);
  endtask

  task automatic offer_value(input logic [31:0] value, input string typed);
    if (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    if (typed.len() != 0) queue_typed_text(typed);
    else queue_text_of(value, radix_now);
    s_axis_tdata  <= value;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // receiver: random stalls, a calm stretch, and one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_asks != hold_seen) begin
      hold_seen     <= hold_asks;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin : check_chars
    char_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (text_due_q.size() == 0) begin
        $error("unexpected character word %h (last %b)", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = text_due_q.pop_front();
        if (m_axis_tdata !== want.code) begin
          $error("character: expected %h, actual %h", want.code, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_char: expected %b, actual %b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("integer_to_ascii_radix_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [5:0]  row_radix;
    logic [31:0] row_value;
    string       row_text;
    logic [5:0]  phase_radix [10];
    rst_ni <= 1'b0;
    phase_radix = '{6'd10, 6'd16, 6'd2, 6'd36, 6'd8, 6'd0, 6'd37, 6'd63, 6'd3, 6'd1};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first rows run on the reset radix
    for (int i = 0; i < DirRows; i++) begin
      fetch_row(i, row_radix, row_value, row_text);
      if (row_radix != radix_now) change_radix({26'd0, row_radix});
      offer_value(row_value, row_text);
    end

    for (int p = 0; p <= 10; p++) begin
      if (p < 10) change_radix({26'd0, phase_radix[p]});
      else change_radix($urandom);
      calm = (p == 4);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 1 && i == 3) hold_asks++;
        offer_value(pick_value(), "");
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (text_due_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("integer_to_ascii_radix_unit verification clean");
    end else begin
      $display("integer_to_ascii_radix_unit verification failed");
    end
    $finish;
  end

endmodule
